### rtl/core/lcdnx_pkg.sv
// Shared types and constants for the character LCD nibble expander sequencer.
// Holds the request and expander-write payloads, the queue entry and the op codes.
// No dependencies.
package lcdnx_pkg;

  typedef enum logic [3:0] {
    OP_CMD       = 4'd0,
    OP_DATA      = 4'd1,
    OP_DISPLAY   = 4'd2,
    OP_ENTRY     = 4'd3,
    OP_CLEAR     = 4'd4,
    OP_HOME      = 4'd5,
    OP_DDRAM     = 4'd6,
    OP_CURSOR    = 4'd7,
    OP_CGRAM     = 4'd8,
    OP_INIT      = 4'd9,
    OP_BACKLIGHT = 4'd10
  } op_t;

  typedef struct packed {
    logic [3:0] operation;
    logic [7:0] value;
    logic [7:0] row;
    logic       option_a;
    logic       option_b;
    logic       option_c;
  } req_t;

  typedef struct packed {
    logic [7:0]  expander_byte;
    logic [15:0] hold_us;
    logic        last;
  } wr_t;

  // One queued job: one or two controller bytes with RS and the backlight level
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two_bytes;
    logic       rs;
    logic       backlight;
  } entry_t;

  localparam logic CFG_PULSE_HOLD   = 1'b0;
  localparam logic CFG_PROCESS_HOLD = 1'b1;

  localparam logic [15:0] PULSE_HOLD_RESET   = 16'd500;
  localparam logic [15:0] PROCESS_HOLD_RESET = 16'd4100;

  localparam int QUEUE_DEPTH = 2;

endpackage

### rtl/core/lcdnx_front.sv
// Front end: accepts requests, works out controller bytes and RS, tracks backlight.
// Pushes one job per writing request into the job queue. Depends on lcdnx_pkg.
module lcdnx_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  lcdnx_pkg::req_t      req,
  output logic                 push,
  output lcdnx_pkg::entry_t    push_entry,
  input  logic                 q_ready
);
  import lcdnx_pkg::*;

  logic       backlight_on;
  logic       backlight_on_next;
  logic       writes;
  logic [7:0] offset;
  logic [7:0] position;
  logic [2:0] slot;

  function automatic logic [7:0] ddram_cmd(input logic [7:0] pos);
    logic [7:0] p;
    p = (pos > 8'hE8) ? 8'h00 : pos;
    return 8'h80 | p;
  endfunction

  assign req_ready = q_ready;

  always_comb begin
    case (req.row)
      8'd1:    offset = 8'h40;
      8'd2:    offset = 8'h14;
      8'd3:    offset = 8'h54;
      default: offset = 8'h00;
    endcase
    position = offset + req.value;
    slot     = (req.value > 8'd7) ? 3'd0 : req.value[2:0];
  end

  always_comb begin
    backlight_on_next    = backlight_on;
    writes               = 1'b1;
    push_entry.byte0     = req.value;
    push_entry.byte1     = 8'h00;
    push_entry.two_bytes = 1'b0;
    push_entry.rs        = 1'b0;
    push_entry.backlight = backlight_on;
    case (op_t'(req.operation))
      OP_CMD:       push_entry.byte0 = req.value;
      OP_DATA:      push_entry.rs = 1'b1;
      OP_DISPLAY:   push_entry.byte0 = {5'b00001, req.option_a, req.option_b, req.option_c};
      OP_ENTRY:     push_entry.byte0 = {6'b000001, req.option_a, req.option_b};
      OP_CLEAR:     push_entry.byte0 = 8'h01;
      OP_HOME:      push_entry.byte0 = 8'h02;
      OP_DDRAM:     push_entry.byte0 = ddram_cmd(req.value);
      OP_CURSOR:    push_entry.byte0 = ddram_cmd(position);
      OP_CGRAM:     push_entry.byte0 = {2'b01, slot, 3'b000};
      OP_INIT: begin
        push_entry.byte0     = 8'h02;
        push_entry.byte1     = {4'b0010, req.option_a, req.option_b, 2'b00};
        push_entry.two_bytes = 1'b1;
      end
      OP_BACKLIGHT: begin
        backlight_on_next = req.option_a;
        writes            = 1'b0;
      end
      default:      writes = 1'b0;
    endcase
  end

  assign push = req_valid && q_ready && writes;

  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_on <= 1'b0;
    end else if (req_valid && req_ready) begin
      backlight_on <= backlight_on_next;
    end
  end

endmodule

### rtl/core/lcdnx_queue.sv
// Short job queue between front and back ends.
// Two entries of lcdnx_pkg::entry_t, registered pointers and fill count.
module lcdnx_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lcdnx_pkg::entry_t    push_entry,
  output logic                 q_ready,
  input  logic                 pop,
  output logic                 q_valid,
  output lcdnx_pkg::entry_t    q_entry
);
  import lcdnx_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;

  assign q_ready = (count != QUEUE_DEPTH[PTR_W:0]);
  assign q_valid = (count != '0);
  assign q_entry = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

endmodule

### rtl/core/lcdnx_back.sv
// Back end: steps each job through its expander writes, one per cycle unless stalled.
// Holds the hold-time registers and the output register. Depends on lcdnx_pkg.
module lcdnx_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  lcdnx_pkg::entry_t    q_entry,
  output logic                 pop,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 wr_valid,
  input  logic                 wr_ready,
  output lcdnx_pkg::wr_t       wr
);
  import lcdnx_pkg::*;

  logic [15:0] pulse_hold_us;
  logic [15:0] process_hold_us;
  entry_t      cur;
  logic        active;
  logic        byte_sel;
  logic        nib_sel;
  logic [1:0]  phase;
  logic        load;
  logic        fin;
  logic [7:0]  cur_byte;
  logic [3:0]  nibble;
  wr_t         wr_next;

  assign load = !wr_valid || wr_ready;
  assign fin  = (phase == 2'd2) && nib_sel && (byte_sel || !cur.two_bytes);
  // Take the next job when idle or as the current job's last write is registered
  assign pop  = q_valid && (!active || (load && fin));

  always_comb begin
    cur_byte              = byte_sel ? cur.byte1 : cur.byte0;
    nibble                = nib_sel ? cur_byte[3:0] : cur_byte[7:4];
    wr_next.expander_byte = {nibble, cur.backlight, (phase == 2'd1), 1'b0, cur.rs};
    wr_next.hold_us       = (phase == 2'd2) ? process_hold_us : pulse_hold_us;
    wr_next.last          = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_hold_us   <= PULSE_HOLD_RESET;
      process_hold_us <= PROCESS_HOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PULSE_HOLD:   pulse_hold_us   <= cfg_data;
        CFG_PROCESS_HOLD: process_hold_us <= cfg_data;
        default:          pulse_hold_us   <= pulse_hold_us;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      wr_valid <= 1'b0;
      byte_sel <= 1'b0;
      nib_sel  <= 1'b0;
      phase    <= 2'd0;
    end else begin
      if (load) begin
        wr_valid <= active;
      end
      if (pop) begin
        active   <= 1'b1;
        byte_sel <= 1'b0;
        nib_sel  <= 1'b0;
        phase    <= 2'd0;
      end else if (load && active) begin
        if (fin) begin
          active <= 1'b0;
        end else if (phase == 2'd2) begin
          phase   <= 2'd0;
          nib_sel <= !nib_sel;
          if (nib_sel) begin
            byte_sel <= 1'b1;
          end
        end else begin
          phase <= phase + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_entry;
    end
    if (load && active) begin
      wr <= wr_next;
    end
  end

endmodule

### rtl/core/char_lcd_nibble_expander_sequencer.sv
// Top level of the character LCD nibble expander sequencer.
// Connects lcdnx_front, lcdnx_queue and lcdnx_back. Depends on lcdnx_pkg.
//
// Takes one LCD operation per request and turns it into expander writes for an
// HD44780-type controller in 4-bit mode: each controller byte goes out high
// nibble first, each nibble as data, enable high, enable low, each write with
// its hold time in microseconds. A command makes 6 writes; init makes 12
// writes. The back-end write sequencer issues one expander write per cycle
// while the write channel is ready. A backlight request makes no writes and is
// accepted whenever the queue has room; unused codes are dropped. A two-entry
// job queue lets requests be accepted while earlier jobs still stream out.
// Write hold times only while no request is in flight.
module char_lcd_nibble_expander_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  lcdnx_pkg::req_t    req,
  output logic               wr_valid,
  input  logic               wr_ready,
  output lcdnx_pkg::wr_t     wr,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import lcdnx_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   q_ready;
  logic   q_valid;
  entry_t q_entry;
  logic   pop;

  assign cfg_ready = 1'b1;

  lcdnx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready)
  );

  lcdnx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  lcdnx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr_valid  (wr_valid),
    .wr_ready  (wr_ready),
    .wr        (wr)
  );

endmodule

### tb/expander_write_check.sv
// Watches the request, config and expander-write channels of the LCD sequencer,
// predicts every expander write and compares it with what the block sends.
// Depends on lcdnx_pkg for the payload types, op codes and register indexes.
module expander_write_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_ready,
  input  lcdnx_pkg::req_t   req,
  input  logic              wr_valid,
  input  logic              wr_ready,
  input  lcdnx_pkg::wr_t    wr,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcdnx_pkg::*;

  logic [15:0] pulse_hold;
  logic [15:0] process_hold;
  logic        backlight;
  wr_t         want_writes[$];
  wr_t         want;
  int          reported;

  function automatic logic [7:0] ddram_byte(input logic [7:0] pos);
    return {1'b1, 7'h00} | ((pos > 8'hE8) ? 8'h00 : pos);
  endfunction

  // data present, enable high, enable low
  task automatic push_nibble(input logic [3:0] nib, input logic rs);
    logic [7:0] base;
    base = {nib, backlight, 1'b0, 1'b0, rs};
    want_writes.push_back(wr_t'{base, pulse_hold, 1'b0});
    want_writes.push_back(wr_t'{base | 8'h04, pulse_hold, 1'b0});
    want_writes.push_back(wr_t'{base, process_hold, 1'b0});
  endtask

  task automatic push_byte(input logic [7:0] b, input logic rs);
    push_nibble(b[7:4], rs);
    push_nibble(b[3:0], rs);
  endtask

  task automatic predict_writes(input req_t r);
    logic [7:0] offset;
    logic [7:0] pos;
    logic [7:0] slot;
    wr_t        tail;
    int         start_n;
    start_n = want_writes.size();
    case (r.operation)
      OP_CMD:     push_byte(r.value, 1'b0);
      OP_DATA:    push_byte(r.value, 1'b1);
      OP_DISPLAY: push_byte({4'h0, 1'b1, r.option_a, r.option_b, r.option_c}, 1'b0);
      OP_ENTRY:   push_byte({6'b000001, r.option_a, r.option_b}, 1'b0);
      OP_CLEAR:   push_byte(8'h01, 1'b0);
      OP_HOME:    push_byte(8'h02, 1'b0);
      OP_DDRAM:   push_byte(ddram_byte(r.value), 1'b0);
      OP_CURSOR: begin
        case (r.row)
          8'd1:    offset = 8'h40;
          8'd2:    offset = 8'h14;
          8'd3:    offset = 8'h54;
          default: offset = 8'h00;
        endcase
        // column wraps modulo 256 before the position clamp
        pos = offset + r.value;
        push_byte(ddram_byte(pos), 1'b0);
      end
      OP_CGRAM: begin
        slot = (r.value > 8'd7) ? 8'd0 : r.value;
        push_byte({2'b01, slot[2:0], 3'b000}, 1'b0);
      end
      OP_INIT: begin
        push_byte(8'h02, 1'b0);
        push_byte({4'h2, r.option_a, r.option_b, 2'b00}, 1'b0);
      end
      OP_BACKLIGHT: backlight = r.option_a;
      default: ;
    endcase
    if (want_writes.size() > start_n) begin
      tail = want_writes.pop_back();
      tail.last = 1'b1;
      want_writes.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pulse_hold   = PULSE_HOLD_RESET;
      process_hold = PROCESS_HOLD_RESET;
      backlight    = 1'b0;
      want_writes.delete();
      errors   = 0;
      pending  = 0;
      reported = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PULSE_HOLD)
          pulse_hold = cfg_data;
        else
          process_hold = cfg_data;
      end
      // a write can never precede its request, so predict first
      if (req_valid && req_ready)
        predict_writes(req);
      if (wr_valid && wr_ready) begin
        if (want_writes.size() == 0) begin
          errors++;
          if (reported < 10)
            $display("%0t: unexpected write byte=%h hold=%0d last=%b",
                     $realtime, wr.expander_byte, wr.hold_us, wr.last);
          reported++;
        end else begin
          want = want_writes.pop_front();
          if (wr.expander_byte !== want.expander_byte || wr.hold_us !== want.hold_us ||
              wr.last !== want.last) begin
            errors++;
            if (reported < 10)
              $display({"%0t: write mismatch exp byte=%h hold=%0d last=%b",
                        " got byte=%h hold=%0d last=%b"},
                       $realtime, want.expander_byte, want.hold_us, want.last,
                       wr.expander_byte, wr.hold_us, wr.last);
            reported++;
          end
        end
      end
      pending = want_writes.size();
    end
  end

endmodule

### tb/tb.sv
// Top of the LCD sequencer testbench: clock, reset, request and config stimulus,
// write-side stalls and the verdict. Depends on lcdnx_pkg, the sequencer RTL and
// expander_write_check.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcdnx_pkg::*;

  localparam logic [3:0] OP_UNUSED_LO = 4'd11;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;
  localparam int RANDOM_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 25;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        wr_valid;
  logic        wr_ready;
  wr_t         wr;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          pending;
  int          burst_left;

  always #2 clk = ~clk;

  char_lcd_nibble_expander_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .wr_valid  (wr_valid),
    .wr_ready  (wr_ready),
    .wr        (wr),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  expander_write_check check (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .wr_valid  (wr_valid),
    .wr_ready  (wr_ready),
    .wr        (wr),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  function automatic req_t mk(input logic [3:0] op, input logic [7:0] value,
                              input logic [7:0] row, input logic a, input logic b,
                              input logic c);
    req_t r;
    r.operation = op;
    r.value     = value;
    r.row       = row;
    r.option_a  = a;
    r.option_b  = b;
    r.option_c  = c;
    return r;
  endfunction

  // Send one request; open a new burst after a random gap when the last one ran out.
  task automatic send(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
  endtask

  // Drop valid, wait for every predicted write, then let a backlight-only request finish.
  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // write-side stalls: a random mode held for a random stretch
  initial begin
    stall_mode_t mode;
    int          n;
    int          tick;
    wr_ready = 1'b0;
    tick = 0;
    forever begin
      mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
      n = $urandom_range(8, 80);
      repeat (n) begin
        @(negedge clk);
        tick++;
        case (mode)
          STALL_NONE:  wr_ready <= 1'b1;
          STALL_LIGHT: wr_ready <= ($urandom_range(0, 3) != 0);
          STALL_HEAVY: wr_ready <= ($urandom_range(0, 3) == 0);
          default:     wr_ready <= (tick % 5 != 0);
        endcase
      end
    end
  end

  initial begin
    req_t        directed[$];
    req_t        r;
    int          sent;
    int          roll;
    logic [15:0] pulse_val;
    logic [15:0] process_val;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_PULSE_HOLD;
    cfg_data   = '0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset hold times
    directed.push_back(mk(OP_CMD, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(OP_CMD, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1));
    directed.push_back(mk(OP_DATA, 8'hA5, 8'h00, 1'b1, 1'b0, 1'b1));
    directed.push_back(mk(OP_DISPLAY, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));
    directed.push_back(mk(OP_DISPLAY, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(OP_ENTRY, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
    directed.push_back(mk(OP_ENTRY, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
    directed.push_back(mk(OP_CLEAR, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(OP_HOME, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(OP_DDRAM, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    // position clamp: E8 passes, anything above goes to 0
    directed.push_back(mk(OP_DDRAM, 8'hE8, 8'h00, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(OP_DDRAM, 8'hE9, 8'h00, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(OP_DDRAM, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(OP_CURSOR, 8'h27, 8'h01, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(OP_CURSOR, 8'hFF, 8'h03, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(OP_CURSOR, 8'hE9, 8'hFF, 1'b0, 1'b0, 1'b0));
    // slot clamp
    directed.push_back(mk(OP_CGRAM, 8'h07, 8'h00, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(OP_CGRAM, 8'h08, 8'h00, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(OP_BACKLIGHT, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
    directed.push_back(mk(OP_INIT, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
    directed.push_back(mk(OP_INIT, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b1));
    directed.push_back(mk(OP_UNUSED_LO, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(OP_UNUSED_HI, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));
    directed.push_back(mk(OP_BACKLIGHT, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b1));
    directed.push_back(mk(OP_DATA, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0));
    foreach (directed[i])
      send(directed[i]);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          pulse_val   = 16'h0000;
          process_val = 16'hFFFF;
        end
        1: begin
          pulse_val   = 16'hFFFF;
          process_val = 16'h0000;
        end
        3: begin
          pulse_val   = PULSE_HOLD_RESET;
          process_val = PROCESS_HOLD_RESET;
        end
        default: begin
          pulse_val   = 16'($urandom_range(0, 16'hFFFF));
          process_val = 16'($urandom_range(0, 16'hFFFF));
        end
      endcase
      write_reg(CFG_PULSE_HOLD, pulse_val);
      write_reg(CFG_PROCESS_HOLD, process_val);

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (roll < 8)
          r.operation = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        else
          r.operation = 4'($urandom_range(OP_CMD, OP_BACKLIGHT));
        r.value    = 8'($urandom_range(0, 255));
        r.row      = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                 : 8'($urandom_range(0, 255));
        r.option_a = 1'($urandom_range(0, 1));
        r.option_b = 1'($urandom_range(0, 1));
        r.option_c = 1'($urandom_range(0, 1));
        // steer positions and slots toward their clamp edges
        if (r.operation == OP_CGRAM && $urandom_range(0, 1) == 0)
          r.value = 8'($urandom_range(0, 9));
        if ((r.operation == OP_DDRAM || r.operation == OP_CURSOR) &&
            $urandom_range(0, 2) == 0)
          r.value = 8'($urandom_range(8'hE0, 8'hFF));
        send(r);
        if (r.operation <= OP_BACKLIGHT)
          sent++;
      end
    end

    settle();
    if (errors == 0 && pending == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
